FILE: hdl/vadr_pkg.sv
// Package for the vertex attribute dedup/remap core.
// Holds the default table geometry and the fixed result field widths.
// No dependencies.
package vadr_pkg;

  // Default table depth and index width per attribute.
  localparam int unsigned TABLE_ENTRIES_DEF = 4096;
  localparam int unsigned INDEX_BITS_DEF    = 16;

  // Fixed widths of the input fields and the result fields.
  localparam int unsigned IN_IDX_W = 16;
  localparam int unsigned VI_W     = 12;
  localparam int unsigned VC_W     = 13;

endpackage

FILE: hdl/vertex_attribute_dedup_remap_core.sv
// Vertex attribute dedup/remap core: welds face-corner index triples into dense vertex numbers.
// Uses vadr_pkg for default geometry and result widths.
// Holds a hash table memory with one write port and a registered read port.

// A command (start while busy is low) is either a remap of one corner triple or a clear of the
// table. Each command produces exactly one result, shown for one cycle with done_o high; the
// receiver cannot stall, so capture it on that cycle. A remap answers once the home slot holds
// the triple or is empty, and otherwise probes the following slots in turn; the table is a
// hash table with linear probing, and one compare against one registered memory read is done per
// cycle. A new triple against a full table probes every slot before it is refused. A clear
// returns its all-zero result on the cycle after the transfer and then sweeps the table memory,
// one slot per cycle, with busy high. The same sweep runs right after reset before the first
// command is taken. The has_texcoords register may be written at any time through
// cfg_we_i / cfg_wdata_i.
module vertex_attribute_dedup_remap_core #(
  parameter int unsigned TABLE_ENTRIES = vadr_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned INDEX_BITS    = vadr_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [vadr_pkg::IN_IDX_W-1:0] position_index_i,
  input  logic [vadr_pkg::IN_IDX_W-1:0] texcoord_index_i,
  input  logic [vadr_pkg::IN_IDX_W-1:0] normal_index_i,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // result strobe
  output logic                          done_o,
  output logic [vadr_pkg::VI_W-1:0]     vertex_index_o,
  output logic                          first_seen_o,
  output logic                          table_full_o,
  output logic [vadr_pkg::VC_W-1:0]     vertex_count_o
);

  localparam int unsigned SLOT_BITS = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KEY_W     = 3 * INDEX_BITS;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0]     FULL_CNT  = CNT_W'(TABLE_ENTRIES);

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;

  // One table slot: valid flag, packed key, assigned vertex number.
  typedef struct packed {
    logic                 valid;
    logic [KEY_W-1:0]     key;
    logic [SLOT_BITS-1:0] num;
  } entry_t;

  // Home slot: XOR-fold the key down to the slot width, then bring it into range.
  // Lookup results do not depend on which slot a key lands in, only on the order of the commands.
  function automatic logic [SLOT_BITS-1:0] home_slot(input logic [KEY_W-1:0] key);
    logic [SLOT_BITS-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % SLOT_BITS] = h[i % SLOT_BITS] ^ key[i];
    end
    if ({1'b0, h} >= (SLOT_BITS + 1)'(TABLE_ENTRIES)) begin
      h = SLOT_BITS'({1'b0, h} - (SLOT_BITS + 1)'(TABLE_ENTRIES));
    end
    return h;
  endfunction

  logic [1:0]           state_q, state_d;
  logic [SLOT_BITS-1:0] slot_q, slot_d;
  logic [SLOT_BITS-1:0] probe_q, probe_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 has_tex_q;
  logic                 done_q, done_d;
  logic [SLOT_BITS-1:0] vi_q, vi_d;
  logic                 first_q, first_d;
  logic                 full_q, full_d;

  logic                 mem_we;
  entry_t               mem_wdata;
  entry_t               rd_q;
  entry_t               table_mem [TABLE_ENTRIES];

  logic [INDEX_BITS-1:0] pos_k, tex_k, nrm_k;
  logic [KEY_W-1:0]      key_c;
  logic [SLOT_BITS-1:0]  slot_inc;

  // Build the packed key; with texcoords off the texcoord part is the all-ones key.
  assign pos_k = INDEX_BITS'(position_index_i);
  assign tex_k = has_tex_q ? INDEX_BITS'(texcoord_index_i) : '1;
  assign nrm_k = INDEX_BITS'(normal_index_i);
  assign key_c = {pos_k, tex_k, nrm_k};

  // Linear probe step with wrap at the last slot.
  assign slot_inc = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    probe_d   = probe_q;
    key_d     = key_q;
    count_d   = count_q;
    done_d    = 1'b0;
    vi_d      = vi_q;
    first_d   = first_q;
    full_d    = full_q;
    mem_we    = 1'b0;
    mem_wdata = '{valid: 1'b0, key: key_q, num: count_q[SLOT_BITS-1:0]};
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (action_i) begin
            // Clear: answer at once, then sweep the valid flags out of the table.
            count_d = '0;
            done_d  = 1'b1;
            vi_d    = '0;
            first_d = 1'b0;
            full_d  = 1'b0;
            slot_d  = '0;
            state_d = ST_SWEEP;
          end else begin
            key_d   = key_c;
            slot_d  = home_slot(key_c);
            probe_d = '0;
            state_d = ST_PROBE;
          end
        end
      end
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (slot_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end else begin
          slot_d = slot_inc;
        end
      end
      ST_PROBE: begin
        if (!rd_q.valid) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (count_q != FULL_CNT) begin
            // Empty slot: insert the key with the next dense number.
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b1;
            vi_d            = count_q[SLOT_BITS-1:0];
            first_d         = 1'b1;
            full_d          = 1'b0;
            count_d         = count_q + 1'b1;
          end else begin
            vi_d    = '0;
            first_d = 1'b0;
            full_d  = 1'b1;
          end
        end else if (rd_q.key == key_q) begin
          done_d  = 1'b1;
          vi_d    = rd_q.num;
          first_d = 1'b0;
          full_d  = 1'b0;
          state_d = ST_IDLE;
        end else if (probe_q == LAST_SLOT) begin
          // Every slot probed without a match or a hole: table is full.
          done_d  = 1'b1;
          vi_d    = '0;
          first_d = 1'b0;
          full_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          slot_d  = slot_inc;
          probe_d = probe_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state. Reset starts with a sweep so every slot reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      slot_q    <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
      has_tex_q <= 1'b1;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        has_tex_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: hold the key under probe and the pending result.
  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
    key_q   <= key_d;
    vi_q    <= vi_d;
    first_q <= first_d;
    full_q  <= full_d;
  end

  // Table memory: one write port at the current slot, registered read at the next slot,
  // so the probe state always sees the entry of slot_q.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[slot_q] <= mem_wdata;
    end
    rd_q <= table_mem[slot_d];
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign vertex_index_o = vadr_pkg::VI_W'(vi_q);
  assign first_seen_o   = first_q;
  assign table_full_o   = full_q;
  assign vertex_count_o = vadr_pkg::VC_W'(count_q);

  // A result never claims both a fresh insert and a refused insert.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(first_seen_o && table_full_o))
    else $error("first_seen and table_full both set");

  // A fresh vertex always gets the number just below the new count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && first_seen_o) |-> (vertex_index_o == vertex_count_o[11:0] - 12'd1))
    else $error("new vertex number does not match count");

  // A clear transfer answers on the next cycle with an empty table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i) |=> (done_o && vertex_count_o == '0 && busy))
    else $error("clear did not answer with an empty table");

  // Every transfer keeps the block busy on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after a transfer");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for vertex_attribute_dedup_remap_core.
// Depends on vadr_pkg and the core RTL only; a scoreboard class predicts each
// welded vertex number and plain tasks drive commands and the texcoord register.
module testbench;

  localparam int unsigned IN_IDX_W = vadr_pkg::IN_IDX_W;
  localparam int unsigned VI_W     = vadr_pkg::VI_W;
  localparam int unsigned VC_W     = vadr_pkg::VC_W;
  localparam int unsigned ENTRIES  = vadr_pkg::TABLE_ENTRIES_DEF;
  localparam int unsigned KEY_W    = 3 * IN_IDX_W;

  localparam logic ACT_REMAP = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;
  localparam logic TEX_OFF   = 1'b0;
  localparam logic TEX_ON    = 1'b1;

  localparam logic [IN_IDX_W-1:0] IDX_MAX = {IN_IDX_W{1'b1}};

  // Worst case per command: a full-table probe or a post-clear sweep plus the longest
  // sender gap; the limit covers the roughly 1900 commands of the run at that cost.
  localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;
  localparam int unsigned     TAIL_CYCLES = 64;
  localparam int unsigned     PHASE_ITEMS = 460;
  localparam int unsigned     POOL_SIZE   = 24;
  localparam int unsigned     MAX_GAP     = 6;

  typedef struct packed {
    logic [VI_W-1:0] vertex_index;
    logic            first_seen;
    logic            table_full;
    logic [VC_W-1:0] vertex_count;
  } weld_result_t;

  // Scoreboard: keeps its own copy of the texcoord mode and of the distinct triples,
  // predicts one result per accepted command and checks results in order.
  class weld_scoreboard;
    logic         has_tex;
    int unsigned  vertex_of_key[logic [KEY_W-1:0]];
    int unsigned  distinct;
    weld_result_t expected_vertices[$];
    int unsigned  errors, n_results, n_new, n_hit, n_full, n_clear, n_cmds;

    function new();
      has_tex   = TEX_ON;
      distinct  = 0;
      errors    = 0;
      n_results = 0;
      n_new     = 0;
      n_hit     = 0;
      n_full    = 0;
      n_clear   = 0;
      n_cmds    = 0;
    endfunction

    // Note one accepted command and queue the result it must produce.
    function void note_transfer(logic act, logic [IN_IDX_W-1:0] pos,
                                logic [IN_IDX_W-1:0] tex, logic [IN_IDX_W-1:0] nrm);
      logic [KEY_W-1:0] key;
      weld_result_t     res;
      res = '0;
      n_cmds++;
      if (act == ACT_CLEAR) begin
        vertex_of_key.delete();
        distinct = 0;
        n_clear++;
      end else begin
        // With texcoords off the middle field collapses to the all-ones key.
        key = {pos, (has_tex == TEX_ON) ? tex : IDX_MAX, nrm};
        if (vertex_of_key.exists(key)) begin
          res.vertex_index = VI_W'(vertex_of_key[key]);
          n_hit++;
        end else if (distinct >= ENTRIES) begin
          res.table_full = 1'b1;
          n_full++;
        end else begin
          vertex_of_key[key] = distinct;
          res.vertex_index   = VI_W'(distinct);
          res.first_seen     = 1'b1;
          distinct++;
          n_new++;
        end
        res.vertex_count = VC_W'(distinct);
      end
      expected_vertices = {expected_vertices, res};
    endfunction

    task report(string msg);
      if (errors < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(weld_result_t got);
      weld_result_t want;
      if (expected_vertices.size() == 0) begin
        report($sformatf("result with nothing outstanding: vi=%0d first=%0b full=%0b vc=%0d",
                         got.vertex_index, got.first_seen, got.table_full, got.vertex_count));
        return;
      end
      want = expected_vertices.pop_front();
      n_results++;
      if (got.vertex_index !== want.vertex_index)
        report($sformatf("result %0d vertex_index got %0d want %0d",
                         n_results, got.vertex_index, want.vertex_index));
      if (got.first_seen !== want.first_seen)
        report($sformatf("result %0d first_seen got %0b want %0b",
                         n_results, got.first_seen, want.first_seen));
      if (got.table_full !== want.table_full)
        report($sformatf("result %0d table_full got %0b want %0b",
                         n_results, got.table_full, want.table_full));
      if (got.vertex_count !== want.vertex_count)
        report($sformatf("result %0d vertex_count got %0d want %0d",
                         n_results, got.vertex_count, want.vertex_count));
    endtask
  endclass

  // Clock, reset and DUT-facing signals; every input starts at a known value.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                action_i    = ACT_REMAP;
  logic [IN_IDX_W-1:0] position_index_i = '0;
  logic [IN_IDX_W-1:0] texcoord_index_i = '0;
  logic [IN_IDX_W-1:0] normal_index_i   = '0;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_wdata_i = TEX_ON;
  logic                busy;
  logic                done_o;
  logic [VI_W-1:0]     vertex_index_o;
  logic                first_seen_o;
  logic                table_full_o;
  logic [VC_W-1:0]     vertex_count_o;

  longint unsigned cycle_count = 0;
  weld_scoreboard  board = new();

  // Random index pool so the random phases revisit triples and hit the table.
  logic [IN_IDX_W-1:0] pool [POOL_SIZE][3];

  vertex_attribute_dedup_remap_core #(
    .TABLE_ENTRIES(ENTRIES),
    .INDEX_BITS   (vadr_pkg::INDEX_BITS_DEF)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .position_index_i(position_index_i),
    .texcoord_index_i(texcoord_index_i),
    .normal_index_i  (normal_index_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .vertex_index_o  (vertex_index_o),
    .first_seen_o    (first_seen_o),
    .table_full_o    (table_full_o),
    .vertex_count_o  (vertex_count_o)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: end the run if the block stops answering.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, board.expected_vertices.size());
      $display("vertex_attribute_dedup_remap_core test failed");
      $finish;
    end
  end

  // Result monitor: a result lives for exactly one cycle, so take it at the edge
  // that ends the strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_result('{vertex_index: vertex_index_o, first_seen: first_seen_o,
                           table_full: table_full_o, vertex_count: vertex_count_o});
    end
  end

  // Present one command and hold it until the transfer happens (start high, busy
  // low at an edge). Afterwards either leave start high for the next command or
  // drop it for a random gap; the gap fields carry junk that must be ignored.
  task automatic issue_command(input logic act, input logic [IN_IDX_W-1:0] pos,
                               input logic [IN_IDX_W-1:0] tex,
                               input logic [IN_IDX_W-1:0] nrm, input int unsigned idle_pct);
    start            <= 1'b1;
    action_i         <= act;
    position_index_i <= pos;
    texcoord_index_i <= tex;
    normal_index_i   <= nrm;
    do @(posedge clk_i); while (busy);
    board.note_transfer(act, pos, tex, nrm);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start            <= 1'b0;
      action_i         <= 1'($urandom);
      position_index_i <= IN_IDX_W'($urandom);
      texcoord_index_i <= IN_IDX_W'($urandom);
      normal_index_i   <= IN_IDX_W'($urandom);
      repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every predicted result has been seen.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.expected_vertices.size() != 0) @(posedge clk_i);
  endtask

  // Write the texcoord mode only with nothing in flight.
  task automatic write_texcoord_mode(input logic mode);
    drain_results();
    while (busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.has_tex = mode;
    @(posedge clk_i);
  endtask

  // Corner cases: field extremes, repeats, clear with junk fields, and key
  // aliasing between an all-ones texcoord and texcoords switched off.
  task automatic run_directed();
    issue_command(ACT_REMAP, 16'h0000, 16'h0000, 16'h0000, 37);
    issue_command(ACT_REMAP, IDX_MAX,  IDX_MAX,  IDX_MAX,  37);
    issue_command(ACT_REMAP, 16'h0000, 16'h0000, 16'h0000, 37);
    issue_command(ACT_REMAP, IDX_MAX,  16'h0000, IDX_MAX,  37);
    issue_command(ACT_REMAP, 16'h0000, IDX_MAX,  16'h0000, 37);
    issue_command(ACT_REMAP, 16'h0000, 16'h0000, IDX_MAX,  37);
    issue_command(ACT_REMAP, IDX_MAX,  IDX_MAX,  IDX_MAX,  37);
    issue_command(ACT_CLEAR, 16'hA5A5, 16'h5A5A, 16'hFFFF, 37);
    issue_command(ACT_REMAP, IDX_MAX,  IDX_MAX,  IDX_MAX,  0);
    issue_command(ACT_REMAP, 16'h1234, IDX_MAX,  16'h5678, 0);
    issue_command(ACT_REMAP, 16'h1234, 16'h0000, 16'h5678, 0);
    write_texcoord_mode(TEX_OFF);
    // Texcoord ignored: the first three land on the all-ones texcoord vertices above; the last two share a new vertex.
    issue_command(ACT_REMAP, 16'h1234, 16'h0000, 16'h5678, 54);
    issue_command(ACT_REMAP, 16'h1234, 16'hBEEF, 16'h5678, 54);
    issue_command(ACT_REMAP, IDX_MAX,  16'h0000, IDX_MAX,  54);
    issue_command(ACT_REMAP, 16'h0000, 16'h0000, 16'h0000, 54);
    issue_command(ACT_REMAP, 16'h0000, 16'h1111, 16'h0000, 54);
    write_texcoord_mode(TEX_ON);
    issue_command(ACT_REMAP, 16'h0000, 16'h0000, 16'h0000, 0);
    issue_command(ACT_REMAP, 16'h0000, IDX_MAX,  16'h0000, 0);
    issue_command(ACT_REMAP, 16'h1234, 16'hBEEF, 16'h5678, 0);
    issue_command(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 0);
    issue_command(ACT_REMAP, 16'h1234, 16'hBEEF, 16'h5678, 0);
  endtask

  // Mostly revisit a small pool of triples (plain, one bit off, or texcoord forced
  // to all ones) so hits and near misses dominate; the rest is fresh noise and the
  // odd clear.
  task automatic run_random_phase(input logic mode, input int unsigned idle_pct);
    int unsigned         r, sel, fld;
    int unsigned         pct;
    logic [IN_IDX_W-1:0] pos, tex, nrm;
    write_texcoord_mode(mode);
    for (int unsigned s = 0; s < POOL_SIZE; s++)
      for (int unsigned f = 0; f < 3; f++) pool[s][f] = IN_IDX_W'($urandom);
    pct = idle_pct;
    for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
      // Every 50 items, choose at random between stretches with and without sender gaps.
      if (i % 50 == 0) pct = ($urandom_range(2) == 0) ? 0 : idle_pct;
      r   = $urandom_range(999);
      sel = $urandom_range(POOL_SIZE - 1);
      pos = pool[sel][0];
      tex = pool[sel][1];
      nrm = pool[sel][2];
      if (r < 15) begin
        issue_command(ACT_CLEAR, IN_IDX_W'($urandom), IN_IDX_W'($urandom),
                      IN_IDX_W'($urandom), pct);
        continue;
      end else if (r < 600) begin
        if (mode == TEX_OFF && $urandom_range(2) == 0) tex = IN_IDX_W'($urandom);
      end else if (r < 750) begin
        fld = $urandom_range(2);
        if (fld == 0) pos[$urandom_range(IN_IDX_W - 1)] ^= 1'b1;
        else if (fld == 1) tex[$urandom_range(IN_IDX_W - 1)] ^= 1'b1;
        else nrm[$urandom_range(IN_IDX_W - 1)] ^= 1'b1;
      end else if (r < 800) begin
        tex = IDX_MAX;
      end else begin
        pos = IN_IDX_W'($urandom);
        tex = IN_IDX_W'($urandom);
        nrm = IN_IDX_W'($urandom);
      end
      issue_command(ACT_REMAP, pos, tex, nrm, pct);
    end
  endtask

  initial begin
    // Start in reset and then release it; the block then sweeps its table with busy high,
    // which the first transfer simply waits out.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    write_texcoord_mode(TEX_ON);

    // Idle phases: none, sender 54%, none, sender 37% (there is no receiver side to idle).
    // Flip the texcoord mode between phases without clearing to exercise aliasing.
    run_random_phase(TEX_OFF, 0);
    run_random_phase(TEX_ON,  54);
    run_random_phase(TEX_OFF, 0);
    run_random_phase(TEX_ON,  37);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d commands: %0d new vertices, %0d repeat hits, %0d full refusals,",
             board.n_cmds, board.n_new, board.n_hit, board.n_full);
    $display("%0d clears, %0d results checked, %0d mismatches, %0d cycles",
             board.n_clear, board.n_results, board.errors, cycle_count);
    if (board.errors == 0 && board.expected_vertices.size() == 0) begin
      $display("vertex_attribute_dedup_remap_core test passed");
    end else begin
      $display("vertex_attribute_dedup_remap_core test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/vadr_pkg.sv
hdl/vertex_attribute_dedup_remap_core.sv
verif/testbench.sv
